[rtl/core/scta_pkg.sv]
// Package for the scored candidate table: widths, codes, entry layout and
// the command and status structs passed between controller and datapath.
// No dependencies.
package scta_pkg;

  // Table geometry
  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  // Field widths
  localparam int KEY_W = 64;
  localparam int TAG_W = 64;
  localparam int FIT_W = 17;
  localparam int CMD_W = 2;
  localparam int ST_W  = 3;
  localparam int TOT_W = 5;
  localparam int BIX_W = 4;

  // Fitness 1.0 in unsigned Q1.16
  localparam logic [FIT_W-1:0] FIT_ONE = 17'h10000;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_SELECT = 2'd2
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_EXISTS    = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_DRAIN,
    S_FIN
  } state_t;

  // One stored candidate
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic [FIT_W-1:0] fit;
    logic             elig;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture the input transaction
    logic rd;      // issue a table read and advance the scan index
    logic finish;  // commit and load the result register
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             fit_bad;
    logic             count_zero;
    logic             scan_last;
  } sts_t;

endpackage

[rtl/core/scta_in_if.sv]
// Input channel of the scored candidate table: valid/ready plus one command.
// Depends on scta_pkg.
interface scta_in_if import scta_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [KEY_W-1:0] candidate_key;
  logic [TAG_W-1:0] provenance_tag;
  logic [FIT_W-1:0] fitness_value;
  logic             is_eligible;

  modport source (output valid, command, candidate_key, provenance_tag, fitness_value,
                  is_eligible, input ready);
  modport sink   (input valid, command, candidate_key, provenance_tag, fitness_value,
                  is_eligible, output ready);
endinterface

[rtl/core/scta_out_if.sv]
// Result channel of the scored candidate table: valid/ready plus one result.
// Depends on scta_pkg.
interface scta_out_if import scta_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [TOT_W-1:0] entry_total;
  logic [BIX_W-1:0] best_index;
  logic [KEY_W-1:0] best_key;
  logic [TAG_W-1:0] best_tag;
  logic [FIT_W-1:0] best_fitness;

  modport source (output valid, status, entry_total, best_index, best_key, best_tag,
                  best_fitness, input ready);
  modport sink   (input valid, status, entry_total, best_index, best_key, best_tag,
                  best_fitness, output ready);
endinterface

[rtl/core/scta_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module scta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

[rtl/core/scta_ctrl.sv]
// Controller of the scored candidate table: sequences capture, table scan
// and result hand-off. Depends on scta_pkg.
module scta_ctrl import scta_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output ctl_t ctl,
  input  sts_t sts
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // State and result-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    ctl           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        // skip the scan for clear, bad fitness, empty table or unknown code
        if ((sts.cmd == CMD_ADD && !sts.fit_bad && !sts.count_zero) ||
            (sts.cmd == CMD_SELECT && !sts.count_zero)) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SCAN: begin
        ctl.rd = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last read data is compared in this cycle
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          ctl.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

[rtl/core/scta_dp.sv]
// Datapath of the scored candidate table: input capture, entry count, table
// RAM, scan compare for duplicate key and best fitness, result register.
// Depends on scta_pkg and scta_ram.
module scta_dp import scta_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  ctl_t             ctl,
  output sts_t             sts,
  input  logic [CMD_W-1:0] in_command,
  input  logic [KEY_W-1:0] in_key,
  input  logic [TAG_W-1:0] in_tag,
  input  logic [FIT_W-1:0] in_fit,
  input  logic             in_elig,
  output logic [ST_W-1:0]  out_status,
  output logic [TOT_W-1:0] out_total,
  output logic [BIX_W-1:0] out_index,
  output logic [KEY_W-1:0] out_key,
  output logic [TAG_W-1:0] out_tag,
  output logic [FIT_W-1:0] out_fit
);

  // Captured transaction
  logic [CMD_W-1:0] cmd_r;
  logic [KEY_W-1:0] key_r;
  logic [TAG_W-1:0] tag_r;
  logic [FIT_W-1:0] fit_r;
  logic             elig_r;

  // Table state and scan
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] scan_idx_r;
  logic             rd_vld_r;
  logic [IDX_W-1:0] rd_idx_r;
  entry_t           rd_data;
  entry_t           wr_data;
  logic             wr_en;

  // Scan results
  logic             match_r;
  logic             found_r;
  logic [IDX_W-1:0] best_idx_r;
  logic [KEY_W-1:0] best_key_r;
  logic [TAG_W-1:0] best_tag_r;
  logic [FIT_W-1:0] best_fit_r;

  logic             fit_bad;
  status_t          status_nxt;

  // Result register
  logic [ST_W-1:0]  res_status_r;
  logic [TOT_W-1:0] res_total_r;
  logic [BIX_W-1:0] res_index_r;
  logic [KEY_W-1:0] res_key_r;
  logic [TAG_W-1:0] res_tag_r;
  logic [FIT_W-1:0] res_fit_r;

  assign fit_bad = (fit_r > FIT_ONE);

  // Status to the controller
  always_comb begin
    sts.cmd        = cmd_r;
    sts.fit_bad    = fit_bad;
    sts.count_zero = (count_r == '0);
    sts.scan_last  = ((CNT_W'(scan_idx_r) + CNT_W'(1)) == count_r);
  end

  // Capture the transaction
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r  <= in_command;
      key_r  <= in_key;
      tag_r  <= in_tag;
      fit_r  <= in_fit;
      elig_r <= in_elig;
    end
  end

  // Scan index and read pipeline flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r   <= 1'b0;
      scan_idx_r <= '0;
    end else begin
      rd_vld_r <= ctl.rd;
      if (ctl.load) begin
        scan_idx_r <= '0;
      end else if (ctl.rd) begin
        scan_idx_r <= scan_idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= scan_idx_r;
  end

  // Compare returned entries: duplicate key for add, best fitness for select
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      match_r <= 1'b0;
      found_r <= 1'b0;
    end else if (rd_vld_r) begin
      if (rd_data.key == key_r) begin
        match_r <= 1'b1;
      end
      if (rd_data.elig && (!found_r || rd_data.fit > best_fit_r)) begin
        found_r    <= 1'b1;
        best_idx_r <= rd_idx_r;
        best_key_r <= rd_data.key;
        best_tag_r <= rd_data.tag;
        best_fit_r <= rd_data.fit;
      end
    end
  end

  // Outcome of the command and table update
  always_comb begin
    count_nxt  = count_r;
    wr_en      = 1'b0;
    status_nxt = ST_INVALID;
    case (cmd_r)
      CMD_CLEAR: begin
        count_nxt  = '0;
        status_nxt = ST_OK;
      end
      CMD_ADD: begin
        if (fit_bad) begin
          status_nxt = ST_INVALID;
        end else if (match_r) begin
          status_nxt = ST_EXISTS;
        end else if (count_r >= MAX_CNT) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_OK;
          wr_en      = ctl.finish;
          count_nxt  = count_r + CNT_W'(1);
        end
      end
      CMD_SELECT: begin
        status_nxt = found_r ? ST_OK : ST_NOT_FOUND;
      end
      default: begin
        status_nxt = ST_INVALID;
      end
    endcase
  end

  assign wr_data = '{key: key_r, tag: tag_r, fit: fit_r, elig: elig_r};

  // Entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctl.finish) begin
      count_r <= count_nxt;
    end
  end

  scta_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (wr_data),
    .raddr (scan_idx_r),
    .rdata (rd_data)
  );

  // Load the result register; best fields are zero unless a select succeeds
  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      res_status_r <= status_nxt;
      res_total_r  <= TOT_W'(count_nxt);
      if (cmd_r == CMD_SELECT && found_r) begin
        res_index_r <= BIX_W'(best_idx_r);
        res_key_r   <= best_key_r;
        res_tag_r   <= best_tag_r;
        res_fit_r   <= best_fit_r;
      end else begin
        res_index_r <= '0;
        res_key_r   <= '0;
        res_tag_r   <= '0;
        res_fit_r   <= '0;
      end
    end
  end

  assign out_status = res_status_r;
  assign out_total  = res_total_r;
  assign out_index  = res_index_r;
  assign out_key    = res_key_r;
  assign out_tag    = res_tag_r;
  assign out_fit    = res_fit_r;

endmodule

[rtl/core/scored_candidate_table_argmax.sv]
// Scored candidate table with argmax selection.
// Usage:
//   in_ch carries one command per transaction: clear the table, add a
//   candidate (key, provenance tag, Q1.16 fitness, eligibility), or select
//   the eligible entry of greatest fitness (lowest slot wins a tie).
//   out_ch returns one result per command: status, entry count after the
//   command and, on a successful select, the chosen slot and its fields.
// Timing:
//   One command is worked on at a time. Clear, an add with fitness above 1.0,
//   an unused code and any command on an empty table skip the table scan and
//   go from capture through decide to finish; add and select on a non-empty
//   table do one table RAM read per cycle for each held entry, plus capture,
//   decide, drain and finish. The next command is accepted once the result
//   is registered and the controller is back in idle.
// Reset: rst_n (synchronous, active low) empties the table and drops any
//   pending result. Table contents need no clearing pass.
// Back-pressure: a finished result waits in the output register while
//   out_ch.ready is low; the next command is still accepted and scanned, and
//   only its hand-off waits for the register to be taken.
// Depends on scta_pkg, scta_in_if, scta_out_if, scta_ctrl, scta_dp, scta_ram.
module scored_candidate_table_argmax import scta_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  scta_in_if.sink     in_ch,
  scta_out_if.source  out_ch
);

  ctl_t ctl;
  sts_t sts;

  scta_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .ctl       (ctl),
    .sts       (sts)
  );

  scta_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .sts        (sts),
    .in_command (in_ch.command),
    .in_key     (in_ch.candidate_key),
    .in_tag     (in_ch.provenance_tag),
    .in_fit     (in_ch.fitness_value),
    .in_elig    (in_ch.is_eligible),
    .out_status (out_ch.status),
    .out_total  (out_ch.entry_total),
    .out_index  (out_ch.best_index),
    .out_key    (out_ch.best_key),
    .out_tag    (out_ch.best_tag),
    .out_fit    (out_ch.best_fitness)
  );

endmodule

[rtl/core/scta_chk.sv]
// Port-level checker for the scored candidate table, bound to the top level.
// Depends on scta_pkg.
module scta_chk import scta_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [ST_W-1:0]  status,
  input logic [TOT_W-1:0] entry_total,
  input logic [KEY_W-1:0] best_key,
  input logic [TAG_W-1:0] best_tag,
  input logic [FIT_W-1:0] best_fitness
);

  // Hold a result until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // One command at a time: no acceptance straight after an acceptance
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction accepted while busy");

  // Entry count never exceeds the table size
  a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> entry_total <= TOT_W'(MAX_ENTRIES))
    else $error("entry total beyond table size");

  // Results with a status other than OK carry zero best fields; fitness stays <= 1.0
  a_best_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_OK |-> best_key == '0 && best_tag == '0 && best_fitness == '0)
    else $error("best fields set on a failed result");

  a_fit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> best_fitness <= FIT_ONE)
    else $error("reported fitness above 1.0");

endmodule

bind scored_candidate_table_argmax scta_chk u_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .status       (out_ch.status),
  .entry_total  (out_ch.entry_total),
  .best_key     (out_ch.best_key),
  .best_tag     (out_ch.best_tag),
  .best_fitness (out_ch.best_fitness)
);

[verif/scored_candidate_table_argmax_test.sv]
// Self-checking bench for scored_candidate_table_argmax: directed table of commands,
// then weighted random clear/add/select/unused-code traffic, with results checked against a table model.
// Depends on scta_pkg, scta_in_if, scta_out_if and the block itself.
module scored_candidate_table_argmax_test;
  timeunit 1ns;
  timeprecision 1ps;
  import scta_pkg::*;

  localparam int RANDOM_ITEMS = 1872;
  localparam int HOLD_AT      = 300;
  localparam int LONG_HOLD    = 200;
  localparam int TAIL_ITEMS   = 150;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400000;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [KEY_W-1:0] Z64     = '0;
  localparam logic [KEY_W-1:0] ONES64  = '1;
  localparam logic [FIT_W-1:0] FIT_Z   = '0;
  localparam logic [FIT_W-1:0] FIT_BAD = 17'h10001;
  localparam logic [FIT_W-1:0] FIT_MAX = 17'h1FFFF;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic [FIT_W-1:0] fit;
    logic             elig;
  } command_word_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [TOT_W-1:0] total;
    logic [BIX_W-1:0] idx;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic [FIT_W-1:0] fit;
  } table_result_t;

  typedef struct {
    command_word_t c;
    int            reps;
    bit            typed;
    table_result_t want;
  } script_row_t;

  logic clk;
  logic rst_n;

  scta_in_if  in_ch ();
  scta_out_if out_ch ();

  scored_candidate_table_argmax dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Table model state
  int               held;
  logic [KEY_W-1:0] slot_key  [MAX_ENTRIES];
  logic [TAG_W-1:0] slot_tag  [MAX_ENTRIES];
  logic [FIT_W-1:0] slot_fit  [MAX_ENTRIES];
  logic             slot_elig [MAX_ENTRIES];
  logic             slot_chosen [MAX_ENTRIES];

  table_result_t    awaited_results [$];
  script_row_t      script [$];
  logic [KEY_W-1:0] key_pool [32];
  table_result_t    front;
  int               errors;
  int               sent;
  int               cycle_count;
  bit               quiet_tail;

  // Clock and a single reset pulse
  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Apply one command to the table model and return the result it gives
  function automatic table_result_t apply_to_table(input command_word_t c);
    table_result_t r;
    int            best;
    bit            found;
    bit            clash;
    r = '0;
    r.status = ST_INVALID;
    case (c.command)
      CMD_CLEAR: begin
        held = 0;
        foreach (slot_chosen[i]) slot_chosen[i] = 1'b0;
        r.status = ST_OK;
      end
      CMD_ADD: begin
        clash = 1'b0;
        for (int i = 0; i < held; i++)
          if (slot_key[i] == c.key) clash = 1'b1;
        if (c.fit > FIT_ONE) begin
          r.status = ST_INVALID;
        end else if (clash) begin
          r.status = ST_EXISTS;
        end else if (held >= MAX_ENTRIES) begin
          r.status = ST_FULL;
        end else begin
          slot_key[held]    = c.key;
          slot_tag[held]    = c.tag;
          slot_fit[held]    = c.fit;
          slot_elig[held]   = c.elig;
          slot_chosen[held] = 1'b0;
          held++;
          r.status = ST_OK;
        end
      end
      CMD_SELECT: begin
        found = 1'b0;
        best  = 0;
        for (int i = 0; i < held; i++) begin
          slot_chosen[i] = 1'b0;
          if (slot_elig[i] && (!found || slot_fit[i] > slot_fit[best])) begin
            best  = i;
            found = 1'b1;
          end
        end
        if (found) begin
          slot_chosen[best] = 1'b1;
          r.status = ST_OK;
          r.idx    = BIX_W'(best);
          r.key    = slot_key[best];
          r.tag    = slot_tag[best];
          r.fit    = slot_fit[best];
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
    r.total = TOT_W'(held);
    return r;
  endfunction

  function automatic void plan(input command_word_t c, input int reps, input bit typed,
                               input table_result_t want);
    script.push_back('{c, reps, typed, want});
  endfunction

  // Offer one transaction, hold it until taken, then record what should come back
  task automatic offer(input command_word_t c, input bit typed, input table_result_t want);
    table_result_t model;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.command        <= c.command;
    in_ch.candidate_key  <= c.key;
    in_ch.provenance_tag <= c.tag;
    in_ch.fitness_value  <= c.fit;
    in_ch.is_eligible    <= c.elig;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    model = apply_to_table(c);
    awaited_results.push_back(typed ? want : model);
    sent++;
  endtask

  // Stimulus: directed script, then random traffic, then drain and verdict
  initial begin
    command_word_t c;
    int            pick;
    in_ch.valid          <= 1'b0;
    in_ch.command        <= CMD_CLEAR;
    in_ch.candidate_key  <= '0;
    in_ch.provenance_tag <= '0;
    in_ch.fitness_value  <= '0;
    in_ch.is_eligible    <= 1'b0;
    held       = 0;
    errors     = 0;
    sent       = 0;
    quiet_tail = 1'b0;
    foreach (slot_chosen[i]) slot_chosen[i] = 1'b0;
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = Z64;
    key_pool[1] = ONES64;

    // Empty table, bad fitness, unused code, no eligible entry, check ordering
    plan({CMD_SELECT, Z64, Z64, FIT_Z, 1'b0}, 1, 1,
         {ST_NOT_FOUND, 5'd0, 4'd0, Z64, Z64, FIT_Z});
    plan({CMD_ADD, 64'h11, 64'h22, FIT_BAD, 1'b1}, 1, 1,
         {ST_INVALID, 5'd0, 4'd0, Z64, Z64, FIT_Z});
    plan({CMD_UNUSED, ONES64, ONES64, FIT_MAX, 1'b1}, 1, 1,
         {ST_INVALID, 5'd0, 4'd0, Z64, Z64, FIT_Z});
    plan({CMD_ADD, Z64, Z64, FIT_Z, 1'b0}, 1, 1,
         {ST_OK, 5'd1, 4'd0, Z64, Z64, FIT_Z});
    plan({CMD_SELECT, Z64, Z64, FIT_Z, 1'b0}, 1, 1,
         {ST_NOT_FOUND, 5'd1, 4'd0, Z64, Z64, FIT_Z});
    plan({CMD_ADD, ONES64, ONES64, FIT_MAX, 1'b1}, 1, 1,
         {ST_INVALID, 5'd1, 4'd0, Z64, Z64, FIT_Z});
    plan({CMD_ADD, ONES64, ONES64, FIT_ONE, 1'b1}, 1, 1,
         {ST_OK, 5'd2, 4'd0, Z64, Z64, FIT_Z});
    plan({CMD_ADD, Z64, 64'h77, FIT_MAX, 1'b1}, 1, 1,
         {ST_INVALID, 5'd2, 4'd0, Z64, Z64, FIT_Z});
    plan({CMD_ADD, Z64, 64'h77, 17'd5, 1'b1}, 1, 1,
         {ST_EXISTS, 5'd2, 4'd0, Z64, Z64, FIT_Z});
    plan({CMD_SELECT, Z64, Z64, FIT_Z, 1'b0}, 1, 1,
         {ST_OK, 5'd2, 4'd1, ONES64, ONES64, FIT_ONE});
    // Tie on fitness, then fill to capacity
    plan({CMD_ADD, 64'h2, 64'hA5A5_A5A5_A5A5_A5A5, FIT_ONE, 1'b1}, 1, 0, '0);
    plan({CMD_ADD, 64'h100, 64'h5A5A_5A5A_5A5A_5A5A, 17'h08000, 1'b1}, 13, 0, '0);
    plan({CMD_ADD, 64'h200, 64'h1, 17'd3, 1'b1}, 1, 1,
         {ST_FULL, 5'd16, 4'd0, Z64, Z64, FIT_Z});
    plan({CMD_ADD, ONES64, 64'h1, 17'd3, 1'b1}, 1, 1,
         {ST_EXISTS, 5'd16, 4'd0, Z64, Z64, FIT_Z});
    plan({CMD_SELECT, Z64, Z64, FIT_Z, 1'b0}, 1, 0, '0);
    plan({CMD_CLEAR, ONES64, ONES64, FIT_MAX, 1'b1}, 1, 1,
         {ST_OK, 5'd0, 4'd0, Z64, Z64, FIT_Z});

    wait (rst_n);
    @(posedge clk);

    // Walk the script; repeated rows step the key
    foreach (script[n]) begin
      for (int r = 0; r < script[n].reps; r++) begin
        c = script[n].c;
        c.key = c.key + KEY_W'(r);
        offer(c, script[n].typed, script[n].want);
      end
    end

    // Random traffic weighted towards adds so the table fills and overflows
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet_tail = (n >= RANDOM_ITEMS - TAIL_ITEMS);
      pick = $urandom_range(0, 99);
      if (pick < 3) c.command = CMD_CLEAR;
      else if (pick < 5) c.command = CMD_UNUSED;
      else if (pick < 68) c.command = CMD_ADD;
      else c.command = CMD_SELECT;
      c.key  = ($urandom_range(0, 3) != 0) ? key_pool[$urandom_range(0, 31)]
                                            : {$urandom, $urandom};
      c.tag  = {$urandom, $urandom};
      c.elig = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0:       c.fit = FIT_W'($urandom_range(int'(FIT_BAD), int'(FIT_MAX)));
        1:       c.fit = FIT_ONE;
        2:       c.fit = FIT_Z;
        3, 4:    c.fit = FIT_W'($urandom_range(1, 3) * 16'h4000);
        default: c.fit = FIT_W'($urandom_range(0, int'(FIT_ONE)));
      endcase
      offer(c, 1'b0, '0);
    end

    // Drain and report
    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off, none in the tail
  initial begin
    bit held_off;
    held_off = 1'b0;
    out_ch.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!quiet_tail && !held_off && sent >= HOLD_AT) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        held_off = 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    end
  endtask

  // Compare each result transaction with the oldest outstanding expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual status %h total %h",
                 $time, out_ch.status, out_ch.entry_total);
      end else begin
        front = awaited_results.pop_front();
        check_field("status",       64'(front.status), 64'(out_ch.status));
        check_field("entry_total",  64'(front.total),  64'(out_ch.entry_total));
        check_field("best_index",   64'(front.idx),    64'(out_ch.best_index));
        check_field("best_key",     front.key,         out_ch.best_key);
        check_field("best_tag",     front.tag,         out_ch.best_tag);
        check_field("best_fitness", 64'(front.fit),    64'(out_ch.best_fitness));
      end
    end
  end

  // Give up if the run hangs
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

endmodule
